// ===== rtl/cor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants for the circle outline rasterizer
// Word formats, request and register codes, clip helper.
// ----------------------------------------------------------------------------
package cor_pkg;

	localparam int COORD_BITS = 16;   // center coordinate width
	localparam int MAX_DIM    = 4096; // hard limit on visible columns/rows
	localparam int CFG_W      = 13;   // image size register width
	localparam int PIX_W      = 12;   // output pixel coordinate width
	localparam int STEP_W     = 16;   // walk x/y, signed (y may reach -1)
	localparam int DEC_W      = 20;   // decision variable, signed
	localparam int PT_W       = 18;   // center +/- offset, signed
	localparam int COLOR_W    = 24;
	localparam int RADIUS_W   = 14;
	localparam int NPTS       = 8;

	localparam logic [CFG_W-1:0] MAX_DIM_C   = CFG_W'(MAX_DIM);
	localparam logic [CFG_W-1:0] WIDTH_RST   = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST  = CFG_W'(480);

	// request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// configuration register indexes
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic                          req_type;
		logic signed [COORD_BITS-1:0]  center_x;
		logic signed [COORD_BITS-1:0]  center_y;
		logic [RADIUS_W-1:0]           radius;
		logic [COLOR_W-1:0]            color;
	} cor_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               pixel_valid;
		logic               last_of_step;
		logic               circle_finished;
	} cor_out_t;

	// one step's candidate points, ready for draining
	typedef struct packed {
		logic [NPTS-1:0][PIX_W-1:0] px;
		logic [NPTS-1:0][PIX_W-1:0] py;
		logic [NPTS-1:0]            mask;   // visible points
		logic [COLOR_W-1:0]         color;
		logic                       fin;
	} cor_batch_t;

	// point inside [0, lim)
	function automatic logic visible(input logic signed [PT_W-1:0] p,
		input logic [CFG_W-1:0] lim);
		logic [PT_W-2:0] mag;
		mag = p[PT_W-2:0];
		return !p[PT_W-1] && (mag < {{(PT_W-1-CFG_W){1'b0}}, lim});
	endfunction

endpackage

// ===== rtl/circle_outline_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_outline_rasterizer: midpoint circle outline generator with clipping
// Start words load a circle; step words emit up to eight pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall/in_word): a start word (req_type 0)
//    latches center, radius and color and produces no output. A step word
//    (req_type 1) emits the eight octant points of the current walk position,
//    clipped to the image, then advances the walk.
//  - Output channel (out_valid/out_stall/out_word): one word per unstalled cycle.
//    A step with nothing visible (or a step after the circle is done) gives a
//    single word with pixel_valid 0. last_of_step marks each step's final word.
//  - Config port (cfg_we/cfg_index/cfg_wdata): image width and height; write
//    only while idle.
//  - A step word is loaded into the point buffer; its words then pass one
//    by one from the buffer into the output register.
//  - A step holds the point buffer until its last output word (of 1 to 8)
//    leaves it; the next input word is taken in the cycle the last word
//    leaves the buffer. Start words do not use the buffer and emit nothing.
//  - Receiver stall holds the output register and backs up into in_stall.
//  - Reset: no circle active, image 640x480, both channels empty.
// ----------------------------------------------------------------------------
module circle_outline_rasterizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cor_pkg::cor_in_t               in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cor_pkg::cor_out_t              out_word,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [cor_pkg::CFG_W-1:0]      cfg_wdata
);
	import cor_pkg::*;

	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] lim_w, lim_h;
	logic             in_acc, load_ok;
	cor_batch_t       batch;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				CFG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// visible area is capped at MAX_DIM in each direction
	assign lim_w = (width_q  < MAX_DIM_C) ? width_q  : MAX_DIM_C;
	assign lim_h = (height_q < MAX_DIM_C) ? height_q : MAX_DIM_C;

	// buffer busy blocks all input words, starts included
	assign in_stall = !load_ok;
	assign in_acc   = in_valid && load_ok;

	cor_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_acc),
		.in_word(in_word),
		.lim_w  (lim_w),
		.lim_h  (lim_h),
		.batch  (batch)
	);

	cor_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_acc && (in_word.req_type == REQ_STEP)),
		.batch    (batch),
		.load_ok  (load_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	// status words always close their step
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.pixel_valid |-> out_word.last_of_step)
		else $error("status word without last_of_step");

	// pixel writes stay inside the clipped image
	a_pixel_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.pixel_valid |->
		({1'b0, out_word.pixel_x} < lim_w) && ({1'b0, out_word.pixel_y} < lim_h))
		else $error("pixel write outside image");

	// a status word carries no color
	a_status_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.pixel_valid |-> (out_word.pixel_color == '0))
		else $error("status word with color");

endmodule

// ===== rtl/cor_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_step: walk state and point generation
// Holds center, color and the midpoint walk; builds one step's eight
// clipped points from the current state.
// ----------------------------------------------------------------------------
module cor_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cor_pkg::cor_in_t    in_word,
	input  logic [cor_pkg::CFG_W-1:0] lim_w,
	input  logic [cor_pkg::CFG_W-1:0] lim_h,
	output cor_pkg::cor_batch_t batch
);
	import cor_pkg::*;

	logic                         active_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic signed [STEP_W-1:0]     x_q, y_q;
	logic signed [DEC_W-1:0]      d_q;
	logic [COLOR_W-1:0]           color_q;

	logic signed [STEP_W-1:0] x_n, y_n;
	logic signed [DEC_W-1:0]  d_n;
	logic                     done_n;

	// next walk position
	always_comb begin
		logic signed [DEC_W-1:0] xe, de;
		x_n = x_q + STEP_W'(1);
		xe  = {{(DEC_W-STEP_W){x_n[STEP_W-1]}}, x_n};
		de  = {{(DEC_W-STEP_W){1'b0}}, x_n} - {{(DEC_W-STEP_W){y_q[STEP_W-1]}}, y_q};
		if (d_q < 0) begin
			d_n = d_q + (xe <<< 2) + DEC_W'(6);
			y_n = y_q;
		end else begin
			d_n = d_q + (de <<< 2) + DEC_W'(10);
			y_n = y_q - STEP_W'(1);
		end
		done_n = y_n < x_n;
	end

	// eight octant points, clipped
	always_comb begin
		logic signed [PT_W-1:0] cxe, cye, xe, ye;
		logic signed [PT_W-1:0] px [NPTS];
		logic signed [PT_W-1:0] py [NPTS];
		cxe = {{(PT_W-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q};
		cye = {{(PT_W-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q};
		xe  = {{(PT_W-STEP_W){x_q[STEP_W-1]}}, x_q};
		ye  = {{(PT_W-STEP_W){y_q[STEP_W-1]}}, y_q};
		px[0] = cxe + xe; py[0] = cye + ye;
		px[1] = cxe - xe; py[1] = cye + ye;
		px[2] = cxe + xe; py[2] = cye - ye;
		px[3] = cxe - xe; py[3] = cye - ye;
		px[4] = cxe + ye; py[4] = cye + xe;
		px[5] = cxe - ye; py[5] = cye + xe;
		px[6] = cxe + ye; py[6] = cye - xe;
		px[7] = cxe - ye; py[7] = cye - xe;
		for (int i = 0; i < NPTS; i++) begin
			batch.px[i]   = px[i][PIX_W-1:0];
			batch.py[i]   = py[i][PIX_W-1:0];
			batch.mask[i] = active_q && visible(px[i], lim_w) && visible(py[i], lim_h);
		end
		batch.color = color_q;
		batch.fin   = !active_q || done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			color_q  <= '0;
		end else if (accept) begin
			if (in_word.req_type == REQ_START) begin
				active_q <= 1'b1;
				cx_q     <= in_word.center_x;
				cy_q     <= in_word.center_y;
				color_q  <= in_word.color;
				x_q      <= '0;
				y_q      <= {{(STEP_W-RADIUS_W){1'b0}}, in_word.radius};
				d_q      <= DEC_W'(3) - {{(DEC_W-RADIUS_W-1){1'b0}}, in_word.radius, 1'b0};
			end else if (active_q) begin
				x_q      <= x_n;
				y_q      <= y_n;
				d_q      <= d_n;
				active_q <= !done_n;
			end
		end
	end

endmodule

// ===== rtl/cor_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_emit: step buffer and output register
// Holds one step's points and sends the visible ones, lowest index first,
// one word per cycle when not stalled; an empty step sends a single status word.
// ----------------------------------------------------------------------------
module cor_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cor_pkg::cor_batch_t batch,
	output logic                load_ok,
	output logic                out_valid,
	input  logic                out_stall,
	output cor_pkg::cor_out_t   out_word
);
	import cor_pkg::*;

	logic       bv_s1;
	cor_batch_t b_s1;
	logic       ov_s2;
	cor_out_t   w_s2;

	logic [NPTS-1:0] pick, rest;
	logic            adv, emit, last;
	cor_out_t        nxt;

	always_comb begin
		pick = b_s1.mask & (~b_s1.mask + NPTS'(1));
		rest = b_s1.mask & ~pick;
		last = (rest == '0);
		adv  = !ov_s2 || !out_stall;
		emit = bv_s1 && adv;
		load_ok = !bv_s1 || (emit && last);

		nxt = '0;
		for (int i = 0; i < NPTS; i++) begin
			if (pick[i]) begin
				nxt.pixel_x = b_s1.px[i];
				nxt.pixel_y = b_s1.py[i];
			end
		end
		if (b_s1.mask != '0) begin
			nxt.pixel_color = b_s1.color;
			nxt.pixel_valid = 1'b1;
		end
		nxt.last_of_step    = last;
		nxt.circle_finished = b_s1.fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s1 <= 1'b0;
			ov_s2 <= 1'b0;
		end else begin
			if (emit)
				ov_s2 <= 1'b1;
			else if (adv)
				ov_s2 <= 1'b0;
			// a load in the cycle the last word leaves keeps the buffer full
			if (load)
				bv_s1 <= 1'b1;
			else if (emit && last)
				bv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			b_s1 <= batch;
		else if (emit)
			b_s1.mask <= rest;
		if (emit)
			w_s2 <= nxt;
	end

	assign out_valid = ov_s2;
	assign out_word  = w_s2;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circle_outline_rasterizer
// A queue of start/step commands feeds a clocked driver. Every accepted
// command goes through a cycle-free circle walker kept in this bench, which
// queues the pixel words the block has to produce. A clocked monitor checks
// each pixel word against the oldest prediction. Both sides idle at random.
// Image size is changed between phases, only when the block is empty.
// ----------------------------------------------------------------------------
module tb;
	import cor_pkg::*;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 16;   // margin after the last word is back
	localparam int LONG_HOLD    = 400;  // receiver back-pressure stretch
	localparam int MAX_REPORTS  = 30;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	cor_in_t           in_word;
	logic              out_valid;
	logic              out_stall;
	cor_out_t          out_word;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	// circle walker mirror, same values as the block right after reset
	logic               walk_on = 1'b0;
	int                 ctr_x   = 0;
	int                 ctr_y   = 0;
	int                 walk_x  = 0;
	int                 walk_y  = 0;
	int                 walk_d  = 0;
	logic [COLOR_W-1:0] ink     = '0;
	int                 img_w   = 640;
	int                 img_h   = 480;

	cor_in_t  draw_cmds[$];        // commands not yet offered
	cor_out_t expected_pixels[$];  // pixel words still owed by the block

	int cmds_total    = 0;
	int cmds_taken    = 0;
	int fail_count    = 0;
	int cycle_count   = 0;
	int send_pct      = 20;  // chance per slot that the sender idles
	int recv_pct      = 20;  // chance per cycle that the receiver stalls
	int send_gap      = 0;
	int stall_left    = 0;
	int hold_requests = 0;
	int holds_served  = 0;

	always #10 clk = ~clk;

	circle_outline_rasterizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mostly no gap, some short ones, now and then a long one.
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(7) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	// Walk one command: a start loads the circle, a step yields its pixel words.
	function automatic void rasterize_word(input cor_in_t w);
		int       px[NPTS];
		int       py[NPTS];
		int       lim_w;
		int       lim_h;
		int       x;
		int       y;
		logic     fin;
		cor_out_t o;
		cor_out_t hits[$];
		if (w.req_type == REQ_START) begin
			ctr_x   = w.center_x;   // signed field, sign-extends
			ctr_y   = w.center_y;
			walk_x  = 0;
			walk_y  = w.radius;
			walk_d  = 3 - 2 * walk_y;
			ink     = w.color;
			walk_on = 1'b1;
			return;
		end
		o = '0;
		o.last_of_step = 1'b1;
		// idle or finished walk: a lone status word
		if (!walk_on || walk_y < walk_x) begin
			walk_on = 1'b0;
			o.circle_finished = 1'b1;
			expected_pixels.push_back(o);
			return;
		end
		x = walk_x;
		y = walk_y;
		px[0] = ctr_x + x; py[0] = ctr_y + y;
		px[1] = ctr_x - x; py[1] = ctr_y + y;
		px[2] = ctr_x + x; py[2] = ctr_y - y;
		px[3] = ctr_x - x; py[3] = ctr_y - y;
		px[4] = ctr_x + y; py[4] = ctr_y + x;
		px[5] = ctr_x - y; py[5] = ctr_y + x;
		px[6] = ctr_x + y; py[6] = ctr_y - x;
		px[7] = ctr_x - y; py[7] = ctr_y - x;
		walk_x++;
		if (walk_d < 0) begin
			walk_d += 4 * walk_x + 6;
		end else begin
			walk_d += 4 * (walk_x - walk_y) + 10;
			walk_y--;
		end
		if (walk_y < walk_x)
			walk_on = 1'b0;
		fin   = !walk_on;
		lim_w = (img_w < MAX_DIM) ? img_w : MAX_DIM;
		lim_h = (img_h < MAX_DIM) ? img_h : MAX_DIM;
		for (int i = 0; i < NPTS; i++) begin
			if (px[i] >= 0 && px[i] < lim_w && py[i] >= 0 && py[i] < lim_h) begin
				o.pixel_x         = PIX_W'(px[i]);
				o.pixel_y         = PIX_W'(py[i]);
				o.pixel_color     = ink;
				o.pixel_valid     = 1'b1;
				o.last_of_step    = 1'b0;
				o.circle_finished = fin;
				hits.push_back(o);
			end
		end
		// nothing visible: one empty word still closes the step
		if (hits.size() == 0) begin
			o = '0;
			o.circle_finished = fin;
			hits.push_back(o);
		end
		hits[hits.size() - 1].last_of_step = 1'b1;
		foreach (hits[i])
			expected_pixels.push_back(hits[i]);
	endfunction

	function automatic void check_pixel(input cor_out_t got);
		cor_out_t want;
		if (expected_pixels.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: unexpected pixel word, expected none, got x=%0d y=%0d color=%06h valid=%b last=%b fin=%b",
					$time, got.pixel_x, got.pixel_y, got.pixel_color, got.pixel_valid,
					got.last_of_step, got.circle_finished);
			return;
		end
		want = expected_pixels.pop_front();
		if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
			got.pixel_color !== want.pixel_color || got.pixel_valid !== want.pixel_valid ||
			got.last_of_step !== want.last_of_step ||
			got.circle_finished !== want.circle_finished) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: pixel word mismatch, expected x=%0d y=%0d color=%06h valid=%b last=%b fin=%b, got x=%0d y=%0d color=%06h valid=%b last=%b fin=%b",
					$time, want.pixel_x, want.pixel_y, want.pixel_color, want.pixel_valid,
					want.last_of_step, want.circle_finished, got.pixel_x, got.pixel_y,
					got.pixel_color, got.pixel_valid, got.last_of_step, got.circle_finished);
		end
	endfunction

	// Driver: the offered word holds until taken; prediction runs at the take.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				rasterize_word(in_word);
				cmds_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (draw_cmds.size() > 0) begin
					in_word  <= draw_cmds.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap(send_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stall; a hold request turns into a long stall here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_pixel(out_word);
			if (holds_served != hold_requests) begin
				holds_served++;
				stall_left = LONG_HOLD;
			end
			if (stall_left == 0)
				stall_left = pick_gap(recv_pct);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Only called while the block is empty.
	task automatic write_reg(input logic idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		if (idx == CFG_IMAGE_WIDTH)
			img_w = val & ((1 << CFG_W) - 1);
		else
			img_h = val & ((1 << CFG_W) - 1);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_image(input int w, input int h);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
	endtask

	task automatic queue_word(input cor_in_t w);
		draw_cmds.push_back(w);
		cmds_total++;
	endtask

	function automatic cor_in_t start_word(input int cx, input int cy, input int r,
		input int col);
		cor_in_t w;
		w.req_type = REQ_START;
		w.center_x = COORD_BITS'(cx);
		w.center_y = COORD_BITS'(cy);
		w.radius   = RADIUS_W'(r);
		w.color    = COLOR_W'(col);
		return w;
	endfunction

	// Steps carry junk in the unused fields; the block must ignore it.
	function automatic cor_in_t step_word();
		cor_in_t w;
		w.req_type = REQ_STEP;
		w.center_x = COORD_BITS'($urandom);
		w.center_y = COORD_BITS'($urandom);
		w.radius   = RADIUS_W'($urandom);
		w.color    = COLOR_W'($urandom);
		return w;
	endfunction

	// Wait until every command is taken and every pixel word has come back.
	task automatic wait_drained();
		while (cmds_taken != cmds_total || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One circle: start plus roughly enough steps to finish it. Big radii get
	// only a few steps and are cut short by the next start.
	task automatic add_circle();
		int r;
		int cx;
		int cy;
		int nsteps;
		int span_w;
		int span_h;
		span_w = (img_w < MAX_DIM) ? img_w : MAX_DIM;
		span_h = (img_h < MAX_DIM) ? img_h : MAX_DIM;
		if ($urandom_range(19) == 0) begin
			r      = $urandom_range(16383, 1000);
			cx     = int'($urandom_range(65535)) - 32768;
			cy     = int'($urandom_range(65535)) - 32768;
			nsteps = $urandom_range(6, 1);
		end else begin
			r      = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(16);
			cx     = int'($urandom_range(span_w + 2 * r + 4)) - r - 2;
			cy     = int'($urandom_range(span_h + 2 * r + 4)) - r - 2;
			// about r/sqrt(2) steps, sometimes a couple past the end
			nsteps = (r * 181) / 256 + $urandom_range(2);
		end
		queue_word(start_word(cx, cy, r, $urandom));
		repeat (nsteps) queue_word(step_word());
	endtask

	// Well-formed circles, with some stray words mixed in.
	task automatic random_phase(input int n);
		int stop;
		stop = cmds_total + n;
		while (cmds_total < stop) begin
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(1) == 0)
					queue_word(step_word());
				else
					queue_word(start_word($urandom, $urandom, $urandom, $urandom));
			end else begin
				add_circle();
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset image size (640x480).
		queue_word(step_word());                              // step with no circle loaded
		queue_word(start_word(5, 7, 0, 24'hFFFFFF));          // radius zero: centre eight times
		queue_word(step_word());
		queue_word(step_word());                              // step past the end
		queue_word(start_word(-32768, -32768, 16383, 0));     // most negative centre, max radius
		queue_word(step_word());
		queue_word(start_word(32767, 32767, 16383, 24'hFFFFFF));
		queue_word(step_word());
		queue_word(start_word(0, 0, 5, 24'hA5A5A5));          // clipped at the origin corner
		repeat (5) queue_word(step_word());
		queue_word(start_word(639, 479, 3, 24'h00FF00));      // clipped at the far corner
		repeat (3) queue_word(step_word());
		queue_word(start_word(320, 240, 16383, 24'h123456));  // huge circle, all off screen
		queue_word(step_word());
		queue_word(start_word(100, -2, 2, 24'h0F0F0F));       // restart mid-walk, top edge
		repeat (3) queue_word(step_word());
		wait_drained();

		// Smallest image: a single visible pixel.
		set_image(1, 1);
		send_pct = 30;
		recv_pct = 30;
		random_phase(50);
		wait_drained();

		// Largest image. Long receiver hold while the sender keeps going,
		// then a sender pause until every word is back.
		set_image(4096, 4096);
		send_pct = 15;
		recv_pct = 15;
		hold_requests++;
		random_phase(30);
		wait_drained();
		random_phase(30);
		wait_drained();

		// Zero width hides everything; all-ones height is clamped.
		set_image(0, 8191);
		send_pct = 20;
		recv_pct = 40;
		random_phase(30);
		wait_drained();

		// Random size, no idling on either side.
		set_image($urandom_range(4096, 1), $urandom_range(4096, 1));
		send_pct = 0;
		recv_pct = 0;
		random_phase(60);
		wait_drained();

		// Oversized width, short image.
		set_image(5000, 37);
		send_pct = 40;
		recv_pct = 10;
		random_phase(45);
		wait_drained();

		// Random size, heavy idling.
		set_image($urandom_range(4096, 1), $urandom_range(4096, 1));
		send_pct = 60;
		recv_pct = 60;
		random_phase(50);
		wait_drained();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
